### hdl/ftp_pkg.sv
// shared types, constants and tables of the formation target pose block
package ftp_pkg;

  localparam int MAX_AGENTS   = 64;
  localparam int ANGLE_STEPS  = 16;
  localparam int MAX_TAB      = 24;
  localparam int CORDIC_STEPS = (ANGLE_STEPS > MAX_TAB) ? MAX_TAB : ANGLE_STEPS;
  localparam int STEP_W       = 5;

  // cordic datapath and angle widths
  localparam int DW = 38;
  localparam int AW = 34;

  // 1/K in Q1.30
  localparam logic [30:0] KINV = 31'd652032874;

  localparam logic [7:0] ID_OFFSET = 8'd100;

  // angle increment of ring slots is (idx * recip) >> RECIP_SHIFT
  localparam int RECIP_SHIFT = 13;
  localparam int RECIP_W     = 46;
  localparam int DIV_W       = 54;

  localparam logic [2:0] MODE_RING   = 3'd0;
  localparam logic [2:0] MODE_LINE   = 3'd1;
  localparam logic [2:0] MODE_COLUMN = 3'd2;
  localparam logic [2:0] MODE_VEE    = 3'd3;
  localparam logic [2:0] MODE_WEDGE  = 3'd4;

  localparam logic [31:0] ATAN_TAB [MAX_TAB] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
  };

  function automatic logic [AW-1:0] atan_of(input logic [STEP_W-1:0] k);
    logic [AW-1:0] r;
    r = '0;
    if (k < STEP_W'(MAX_TAB)) begin
      r = AW'(ATAN_TAB[k]);
    end
    return r;
  endfunction

  // item data that rides along the cordic cells
  typedef struct packed {
    logic               ok;
    logic               yzero;
    logic [5:0]         idx;
    logic signed [31:0] lx;
    logic signed [31:0] ly;
    logic signed [31:0] lz;
    logic signed [15:0] qx;
    logic signed [15:0] qy;
    logic signed [15:0] qz;
    logic signed [15:0] qw;
  } side_t;

  typedef struct packed {
    logic                 vld;
    side_t                side;
    logic signed [DW-1:0] x;
    logic signed [DW-1:0] y;
    logic signed [AW-1:0] z;
  } cbus_t;

  // configuration plus values derived from it
  typedef struct packed {
    logic [2:0]         mode;
    logic [15:0]        spacing;
    logic [6:0]         agent_count;
    logic [7:0]         leader_number;
    logic [31:0]        radius;
    logic [RECIP_W-1:0] recip;
    logic               busy;
  } cfg_t;

endpackage

### hdl/ftp_cordic_cell.sv
// one cordic micro-rotation cell, vectoring or rotation, registered output
module ftp_cordic_cell (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic [ftp_pkg::STEP_W-1:0] k_i,
  input  logic                      vec_i,
  input  ftp_pkg::cbus_t            bus_i,
  output ftp_pkg::cbus_t            bus_o
);

  logic signed [ftp_pkg::DW-1:0] xs, ys;
  logic [ftp_pkg::AW-1:0]        at;
  logic                          rot_pos;
  logic                          vld_q;
  ftp_pkg::cbus_t                dat_q, dat_d;

  assign xs = bus_i.x >>> k_i;
  assign ys = bus_i.y >>> k_i;
  assign at = ftp_pkg::atan_of(k_i);
  // vectoring drives y toward zero, rotation drives z toward zero
  assign rot_pos = vec_i ? bus_i.y[ftp_pkg::DW-1] : !bus_i.z[ftp_pkg::AW-1];

  always_comb begin
    dat_d      = bus_i;
    dat_d.x    = rot_pos ? bus_i.x - ys : bus_i.x + ys;
    dat_d.y    = rot_pos ? bus_i.y + xs : bus_i.y - xs;
    dat_d.z    = rot_pos ? bus_i.z - $signed(at) : bus_i.z + $signed(at);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= bus_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dat_q <= dat_d;
    end
  end

  always_comb begin
    bus_o     = dat_q;
    bus_o.vld = vld_q;
  end

endmodule

### hdl/ftp_setup.sv
// configuration registers and the precompute of ring radius and slot step
module ftp_setup (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output ftp_pkg::cfg_t     cfg_o
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_PHI, ST_ROT, ST_SCALE, ST_RAD, ST_REC, ST_DONE
  } state_e;

  localparam logic [1:0] REG_MODE    = 2'd0;
  localparam logic [1:0] REG_SPACING = 2'd1;
  localparam logic [1:0] REG_COUNT   = 2'd2;
  localparam logic [1:0] REG_LEADER  = 2'd3;
  localparam int CNT_W = $clog2(ftp_pkg::DIV_W + 1);

  state_e                        state_q;
  logic [CNT_W-1:0]              cnt_q;
  logic [2:0]                    mode_q;
  logic [15:0]                   spacing_q;
  logic [6:0]                    count_q;
  logic [7:0]                    leader_q;
  logic [ftp_pkg::DIV_W-1:0]     num_q, quo_q, div_num, quo_n;
  logic [31:0]                   den_q, rem_q, div_den, rem_n, sy_q, radius_q;
  logic [ftp_pkg::RECIP_W-1:0]   recip_q;
  logic [32:0]                   rem_sh;
  logic                          ge;
  logic                          wr;
  logic [6:0]                    cnt_sat;
  logic [6:0]                    n_eff;
  logic                          n_small;
  logic                          cell_en;
  ftp_pkg::cbus_t                cell_in, cell_out;
  logic signed [31:0]            ys;
  logic signed [31:0]            kc;
  logic signed [63:0]            yprod;
  logic signed [33:0]            sy_s;

  assign wr = psel & penable & pwrite;

  assign cnt_sat = (count_q > 7'(ftp_pkg::MAX_AGENTS)) ? 7'(ftp_pkg::MAX_AGENTS) : count_q;
  assign n_small = (cnt_sat <= 7'd2);
  assign n_eff   = n_small ? 7'd1 : cnt_sat - 7'd1;

  // operands of the shared restoring divider
  always_comb begin
    case (state_q)
      ST_PHI: begin
        div_num = ftp_pkg::DIV_W'(1) << 31;
        div_den = 32'(n_eff);
      end
      ST_RAD: begin
        div_num = (ftp_pkg::DIV_W'(spacing_q) << 37) + ftp_pkg::DIV_W'(sy_q >> 1);
        div_den = sy_q;
      end
      ST_REC: begin
        div_num = (ftp_pkg::DIV_W'(1) << 45) + ftp_pkg::DIV_W'(n_eff) - ftp_pkg::DIV_W'(1);
        div_den = 32'(n_eff);
      end
      default: begin
        div_num = '0;
        div_den = 32'd1;
      end
    endcase
  end

  assign rem_sh = {rem_q, num_q[ftp_pkg::DIV_W-1]};
  assign ge     = rem_sh >= {1'b0, den_q};
  assign rem_n  = ge ? 32'(rem_sh - {1'b0, den_q}) : rem_sh[31:0];
  assign quo_n  = {quo_q[ftp_pkg::DIV_W-2:0], ge};

  // sin(pi/n) from one rotation of the unit vector, run on a single cell
  always_comb begin
    cell_in      = '0;
    cell_in.vld  = 1'b1;
    cell_in.x    = ftp_pkg::DW'(1) <<< 30;
    cell_in.z    = ftp_pkg::AW'(quo_q[31:0]);
    if (cnt_q != '0) begin
      cell_in = cell_out;
    end
  end

  assign cell_en = (state_q == ST_ROT);

  ftp_cordic_cell u_cell (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (cell_en),
    .k_i    (cnt_q[ftp_pkg::STEP_W-1:0]),
    .vec_i  (1'b0),
    .bus_i  (cell_in),
    .bus_o  (cell_out)
  );

  assign ys    = cell_out.y[31:0];
  assign kc    = {1'b0, ftp_pkg::KINV};
  assign yprod = ys * kc;
  assign sy_s  = 34'((yprod + (64'sd1 <<< 29)) >>> 30);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_PHI;
      cnt_q     <= '0;
      mode_q    <= 3'd0;
      spacing_q <= 16'd256;
      count_q   <= 7'd1;
      leader_q  <= 8'd1;
      num_q     <= '0;
      quo_q     <= '0;
      den_q     <= 32'd1;
      rem_q     <= '0;
      sy_q      <= 32'd1;
      radius_q  <= '0;
      recip_q   <= '0;
    end else if (wr) begin
      case (paddr[3:2])
        REG_MODE:    mode_q    <= pwdata[2:0];
        REG_SPACING: spacing_q <= pwdata[15:0];
        REG_COUNT:   count_q   <= pwdata[6:0];
        REG_LEADER:  leader_q  <= pwdata[7:0];
        default:     mode_q    <= mode_q;
      endcase
      state_q <= ST_PHI;
      cnt_q   <= '0;
    end else begin
      case (state_q)
        ST_PHI, ST_RAD, ST_REC: begin
          if (cnt_q == '0) begin
            num_q <= div_num;
            den_q <= div_den;
            rem_q <= '0;
            quo_q <= '0;
            cnt_q <= CNT_W'(1);
            if (state_q == ST_REC) begin
              radius_q <= n_small ? {8'd0, spacing_q, 8'd0} : quo_q[31:0];
            end
          end else begin
            rem_q <= rem_n;
            num_q <= num_q << 1;
            quo_q <= quo_n;
            if (cnt_q == CNT_W'(ftp_pkg::DIV_W)) begin
              cnt_q <= '0;
              case (state_q)
                ST_PHI:  state_q <= ST_ROT;
                ST_RAD:  state_q <= ST_REC;
                default: state_q <= ST_DONE;
              endcase
            end else begin
              cnt_q <= cnt_q + CNT_W'(1);
            end
          end
        end
        ST_ROT: begin
          if (cnt_q == CNT_W'(ftp_pkg::CORDIC_STEPS - 1)) begin
            cnt_q   <= '0;
            state_q <= ST_SCALE;
          end else begin
            cnt_q <= cnt_q + CNT_W'(1);
          end
        end
        ST_SCALE: begin
          sy_q    <= (sy_s <= 34'sd0) ? 32'd1 : sy_s[31:0];
          state_q <= ST_RAD;
        end
        ST_DONE: begin
          recip_q <= quo_q[ftp_pkg::RECIP_W-1:0];
          state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_MODE:    prdata = {29'd0, mode_q};
      REG_SPACING: prdata = {16'd0, spacing_q};
      REG_COUNT:   prdata = {25'd0, count_q};
      REG_LEADER:  prdata = {24'd0, leader_q};
      default:     prdata = '0;
    endcase
  end

  assign cfg_o.mode          = mode_q;
  assign cfg_o.spacing       = spacing_q;
  assign cfg_o.agent_count   = cnt_sat;
  assign cfg_o.leader_number = leader_q;
  assign cfg_o.radius        = radius_q;
  assign cfg_o.recip         = recip_q;
  assign cfg_o.busy          = (state_q != ST_IDLE);

endmodule

### hdl/formation_target_pose.sv
// top level: formation target pose pipeline with yaw and offset cordic rows
// one transaction per cycle while the output is not stalled and setup is idle
// both rows of cordic cells are pipelined, each cell one micro-rotation
// reset: configuration returns to ring, spacing 1.0, one agent, leader 1; then a
// setup pass (also after every register write) during which
// s_axis_tready stays low while ring radius and slot step are recomputed
module formation_target_pose (
  input  logic         clk_i,
  input  logic         rst_ni,
  // input stream
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // agent_number, leader_x, leader_y, leader_z, quat_x, quat_y, quat_z, quat_w
  input  logic [167:0] s_axis_tdata,
  // result stream
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // target_x, target_y, target_z, target_qx, target_qy, target_qz, target_qw
  output logic [159:0] m_axis_tdata,
  // valid_res
  output logic [0:0]   m_axis_tuser,
  // configuration port
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam int N = ftp_pkg::CORDIC_STEPS;
  localparam int DW = ftp_pkg::DW;
  localparam int AW = ftp_pkg::AW;

  ftp_pkg::cfg_t cfg;

  // whole pipeline moves together; output register frees it
  logic en;
  logic acc;

  ftp_setup u_setup (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg_o   (cfg)
  );

  assign pready = 1'b1;

  logic out_vld_q;
  assign en            = !out_vld_q || m_axis_tready;
  assign s_axis_tready = en && !cfg.busy;
  assign acc           = s_axis_tvalid && s_axis_tready;

  // ---------------------------------------------------------------- decode
  logic [5:0]         in_agent;
  logic [7:0]         li;
  logic [6:0]         n_fol;
  logic signed [8:0]  idx_s;
  ftp_pkg::side_t     in_side;

  assign in_agent = s_axis_tdata[5:0];
  // leader ids above 100 alias to id minus 100
  assign li    = (cfg.leader_number > ftp_pkg::ID_OFFSET) ?
                 cfg.leader_number - ftp_pkg::ID_OFFSET : cfg.leader_number;
  assign n_fol = cfg.agent_count - 7'd1;
  // follower index skips the leader's slot
  assign idx_s = ({2'b0, in_agent} < li) ? $signed({3'b0, in_agent}) - 9'sd1
                                         : $signed({3'b0, in_agent}) - 9'sd2;

  always_comb begin
    in_side.ok    = (cfg.agent_count >= 7'd2) && (cfg.mode <= ftp_pkg::MODE_WEDGE) &&
                    ({2'b0, in_agent} != li) && (idx_s >= 9'sd0) &&
                    (idx_s < $signed({2'b0, n_fol}));
    in_side.yzero = 1'b0;
    in_side.idx   = idx_s[5:0];
    in_side.lx    = s_axis_tdata[37:6];
    in_side.ly    = s_axis_tdata[69:38];
    in_side.lz    = s_axis_tdata[101:70];
    in_side.qx    = s_axis_tdata[117:102];
    in_side.qy    = s_axis_tdata[133:118];
    in_side.qz    = s_axis_tdata[149:134];
    in_side.qw    = s_axis_tdata[165:150];
  end

  logic           s0_vld_q;
  ftp_pkg::side_t s0_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q <= 1'b0;
    end else if (en) begin
      s0_vld_q <= acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_side_q <= in_side;
    end
  end

  // ---------------------------------------------------------------- yaw terms
  logic signed [31:0] p_xy, p_wz, p_ww, p_xx, p_yy, p_zz;
  logic signed [32:0] sum_a;

  assign p_xy  = s0_side_q.qx * s0_side_q.qy;
  assign p_wz  = s0_side_q.qw * s0_side_q.qz;
  assign p_ww  = s0_side_q.qw * s0_side_q.qw;
  assign p_xx  = s0_side_q.qx * s0_side_q.qx;
  assign p_yy  = s0_side_q.qy * s0_side_q.qy;
  assign p_zz  = s0_side_q.qz * s0_side_q.qz;
  assign sum_a = 33'(p_xy) + 33'(p_wz);

  logic              s1_vld_q;
  ftp_pkg::side_t    s1_side_q;
  logic signed [DW-1:0] s1_a_q, s1_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (en) begin
      s1_vld_q <= s0_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_side_q <= s0_side_q;
      s1_a_q    <= DW'(sum_a) <<< 1;
      s1_b_q    <= DW'(p_ww) + DW'(p_xx) - DW'(p_yy) - DW'(p_zz);
    end
  end

  // pre-rotate by half a turn when the cosine term is negative
  ftp_pkg::cbus_t yaw_bus [N+1];

  always_comb begin
    yaw_bus[0].vld        = s1_vld_q;
    yaw_bus[0].side       = s1_side_q;
    yaw_bus[0].side.yzero = (s1_a_q == '0) && (s1_b_q == '0);
    if (s1_b_q < 0) begin
      yaw_bus[0].x = -s1_b_q;
      yaw_bus[0].y = -s1_a_q;
      yaw_bus[0].z = AW'(1) <<< 31;
    end else begin
      yaw_bus[0].x = s1_b_q;
      yaw_bus[0].y = s1_a_q;
      yaw_bus[0].z = '0;
    end
  end

  // ---------------------------------------------------------------- yaw row
  for (genvar i = 0; i < N; i++) begin : g_yaw
    ftp_cordic_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .k_i    (ftp_pkg::STEP_W'(i)),
      .vec_i  (1'b1),
      .bus_i  (yaw_bus[i]),
      .bus_o  (yaw_bus[i+1])
    );
  end

  // ---------------------------------------------------------------- offsets
  ftp_pkg::cbus_t yb;
  logic [31:0]    th;
  logic [23:0]    unit;
  logic [5:0]     rank;
  logic [29:0]    ru;
  logic [30:0]    cu;
  logic [51:0]    inc_p;
  logic signed [AW-1:0] ru_s, cu_s, ox_d, oy_d;
  logic [31:0]    inc_d;

  assign yb    = yaw_bus[N];
  // zero quaternion gives zero yaw
  assign th    = yb.side.yzero ? 32'd0 : yb.z[31:0];
  assign unit  = {cfg.spacing, 8'd0};
  assign rank  = {1'b0, yb.side.idx[5:1]} + 6'd1;
  assign ru    = rank * unit;
  assign cu    = ({1'b0, yb.side.idx} + 7'd1) * unit;
  assign inc_p = yb.side.idx * cfg.recip;
  assign ru_s  = $signed(AW'(ru));
  assign cu_s  = $signed(AW'(cu));

  always_comb begin
    ox_d  = '0;
    oy_d  = '0;
    inc_d = '0;
    case (cfg.mode)
      ftp_pkg::MODE_RING: begin
        ox_d  = $signed(AW'(cfg.radius));
        inc_d = inc_p[ftp_pkg::RECIP_SHIFT +: 32];
      end
      ftp_pkg::MODE_LINE: begin
        oy_d = yb.side.idx[0] ? -ru_s : ru_s;
      end
      ftp_pkg::MODE_COLUMN: begin
        ox_d = -cu_s;
      end
      ftp_pkg::MODE_VEE: begin
        ox_d = -ru_s;
        oy_d = yb.side.idx[0] ? -ru_s : ru_s;
      end
      default: begin
        // wedge: lateral step is half the spacing
        ox_d = -ru_s;
        oy_d = yb.side.idx[0] ? -(ru_s >>> 1) : (ru_s >>> 1);
      end
    endcase
  end

  logic                 s3_vld_q;
  ftp_pkg::side_t       s3_side_q;
  logic signed [AW-1:0] s3_ox_q, s3_oy_q;
  logic [31:0]          s3_th_q, s3_inc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_vld_q <= 1'b0;
    end else if (en) begin
      s3_vld_q <= yb.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_side_q <= yb.side;
      s3_ox_q   <= ox_d;
      s3_oy_q   <= oy_d;
      s3_th_q   <= th;
      s3_inc_q  <= inc_d;
    end
  end

  // fold the angle into a quarter turn either side of zero
  logic [31:0]          phi;
  logic signed [AW-1:0] z0;
  localparam logic signed [AW-1:0] QUARTER = AW'(1) <<< 30;
  localparam logic signed [AW-1:0] HALF    = AW'(1) <<< 31;
  ftp_pkg::cbus_t rot_bus [N+1];

  assign phi = s3_th_q + s3_inc_q;
  assign z0  = AW'($signed(phi));

  always_comb begin
    rot_bus[0].vld  = s3_vld_q;
    rot_bus[0].side = s3_side_q;
    rot_bus[0].x    = DW'(s3_ox_q);
    rot_bus[0].y    = DW'(s3_oy_q);
    rot_bus[0].z    = z0;
    if (z0 > QUARTER) begin
      rot_bus[0].x = -DW'(s3_ox_q);
      rot_bus[0].y = -DW'(s3_oy_q);
      rot_bus[0].z = z0 - HALF;
    end else if (z0 < -QUARTER) begin
      rot_bus[0].x = -DW'(s3_ox_q);
      rot_bus[0].y = -DW'(s3_oy_q);
      rot_bus[0].z = z0 + HALF;
    end
  end

  // ---------------------------------------------------------------- rotation row
  for (genvar i = 0; i < N; i++) begin : g_rot
    ftp_cordic_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .k_i    (ftp_pkg::STEP_W'(i)),
      .vec_i  (1'b0),
      .bus_i  (rot_bus[i]),
      .bus_o  (rot_bus[i+1])
    );
  end

  // ---------------------------------------------------------------- gain correction
  ftp_pkg::cbus_t     rb;
  logic signed [33:0] rx, ry;
  logic signed [31:0] kc;
  logic signed [65:0] px_p, py_p;

  assign rb   = rot_bus[N];
  assign rx   = rb.x[33:0];
  assign ry   = rb.y[33:0];
  assign kc   = {1'b0, ftp_pkg::KINV};
  assign px_p = rx * kc;
  assign py_p = ry * kc;

  logic               s5_vld_q;
  ftp_pkg::side_t     s5_side_q;
  logic signed [65:0] s5_px_q, s5_py_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s5_vld_q <= 1'b0;
    end else if (en) begin
      s5_vld_q <= rb.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s5_side_q <= rb.side;
      s5_px_q   <= px_p;
      s5_py_q   <= py_p;
    end
  end

  // ---------------------------------------------------------------- result
  logic [65:0] px_r, py_r;
  logic [31:0] tx_d, ty_d;

  // round half up, then add to the leader position with wraparound
  assign px_r = s5_px_q + (66'sd1 <<< 29);
  assign py_r = s5_py_q + (66'sd1 <<< 29);
  assign tx_d = s5_side_q.lx + px_r[61:30];
  assign ty_d = s5_side_q.ly + py_r[61:30];

  logic         out_ok_q;
  logic [159:0] out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= s5_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_ok_q <= s5_side_q.ok;
      if (s5_side_q.ok) begin
        out_data_q <= {s5_side_q.qw, s5_side_q.qz, s5_side_q.qy, s5_side_q.qx,
                       s5_side_q.lz, ty_d, tx_d};
      end else begin
        // no target: every field reads zero
        out_data_q <= '0;
      end
    end
  end

  assign m_axis_tvalid   = out_vld_q;
  assign m_axis_tdata    = out_data_q;
  assign m_axis_tuser[0] = out_ok_q;

endmodule
